FILE: src/ale_pkg.sv
// Shared types and codes for the array list engine.
// Request codes, memory address selects and the controller/datapath bundles.
// No dependencies.
package ale_pkg;

	// request kinds carried in req_type
	localparam logic [2:0] REQ_CLEAR  = 3'd0;
	localparam logic [2:0] REQ_GET    = 3'd1;
	localparam logic [2:0] REQ_UPDATE = 3'd2;
	localparam logic [2:0] REQ_INSERT = 3'd3;
	localparam logic [2:0] REQ_DELETE = 3'd4;
	localparam logic [2:0] REQ_APPEND = 3'd5;

	// memory address selects (all zero-based entry indexes)
	localparam logic [2:0] ADDR_POS_M1 = 3'd0;  // position - 1
	localparam logic [2:0] ADDR_POS    = 3'd1;  // position
	localparam logic [2:0] ADDR_LEN    = 3'd2;  // first free entry
	localparam logic [2:0] ADDR_LEN_M1 = 3'd3;  // last used entry
	localparam logic [2:0] ADDR_CUR_P1 = 3'd4;  // cursor + 1
	localparam logic [2:0] ADDR_CUR_M1 = 3'd5;  // cursor - 1

	// length register operations
	localparam logic [1:0] LEN_HOLD  = 2'd0;
	localparam logic [1:0] LEN_CLEAR = 2'd1;
	localparam logic [1:0] LEN_INC   = 2'd2;
	localparam logic [1:0] LEN_DEC   = 2'd3;

	// controller to datapath
	typedef struct packed {
		logic       load_req;    // capture the incoming request word
		logic       res_latch;   // capture the request's ok flag
		logic       out_load;    // load the output register
		logic       rd_en;       // memory read (cursor follows the read address)
		logic [2:0] rd_sel;
		logic       wr_en;       // memory write
		logic [2:0] wr_sel;
		logic       wr_from_rd;  // write data is the last word read, else the request word
		logic [1:0] len_op;
	} ale_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic [2:0] kind;
		logic       req_ok;          // request is legal against the current length
		logic       move;            // entries must be shifted
		logic       last_ins;        // insert shift has reached the target entry
		logic       last_del;        // delete shift has reached the last entry
		logic       out_free;        // output register can take a word
	} ale_stat_t;

endpackage

FILE: src/ale_ctrl.sv
// Sequencing controller for the array list engine.
// Decodes the held request and steps the datapath through reads, shifts and the reply.
// Depends on ale_pkg.
module ale_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  ale_pkg::ale_stat_t  stat,
	output ale_pkg::ale_cmd_t   cmd
);

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_CHECK = 3'd1;
	localparam logic [2:0] ST_SHIFT = 3'd2;
	localparam logic [2:0] ST_INSW  = 3'd3;
	localparam logic [2:0] ST_RESP  = 3'd4;

	logic [2:0] state_q;
	logic [2:0] state_d;

	assign in_stall = (state_q != ST_IDLE);

	// next state and command decode
	always_comb begin
		state_d        = state_q;
		cmd            = '0;
		cmd.rd_sel     = ale_pkg::ADDR_POS_M1;
		cmd.wr_sel     = ale_pkg::ADDR_POS_M1;
		cmd.len_op     = ale_pkg::LEN_HOLD;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.load_req = 1'b1;
					state_d      = ST_CHECK;
				end
			end
			ST_CHECK: begin
				cmd.res_latch = 1'b1;
				state_d       = ST_RESP;
				case (stat.kind)
					ale_pkg::REQ_CLEAR: begin
						cmd.len_op = ale_pkg::LEN_CLEAR;
					end
					ale_pkg::REQ_GET: begin
						cmd.rd_en  = stat.req_ok;
						cmd.rd_sel = ale_pkg::ADDR_POS_M1;
					end
					ale_pkg::REQ_UPDATE: begin
						cmd.wr_en  = stat.req_ok;
						cmd.wr_sel = ale_pkg::ADDR_POS_M1;
					end
					ale_pkg::REQ_APPEND: begin
						if (stat.req_ok) begin
							cmd.wr_en  = 1'b1;
							cmd.wr_sel = ale_pkg::ADDR_LEN;
							cmd.len_op = ale_pkg::LEN_INC;
						end
					end
					ale_pkg::REQ_INSERT: begin
						if (stat.req_ok) begin
							if (stat.move) begin
								// start moving from the top entry downwards
								cmd.rd_en  = 1'b1;
								cmd.rd_sel = ale_pkg::ADDR_LEN_M1;
								state_d    = ST_SHIFT;
							end else begin
								cmd.wr_en  = 1'b1;
								cmd.wr_sel = ale_pkg::ADDR_POS_M1;
								cmd.len_op = ale_pkg::LEN_INC;
							end
						end
					end
					ale_pkg::REQ_DELETE: begin
						if (stat.req_ok) begin
							if (stat.move) begin
								// start moving the entry above the hole
								cmd.rd_en  = 1'b1;
								cmd.rd_sel = ale_pkg::ADDR_POS;
								state_d    = ST_SHIFT;
							end else begin
								cmd.len_op = ale_pkg::LEN_DEC;
							end
						end
					end
					default: begin
					end
				endcase
			end
			ST_SHIFT: begin
				// one entry moved per cycle: write the word read last cycle, read the next
				cmd.wr_en      = 1'b1;
				cmd.wr_from_rd = 1'b1;
				if (stat.kind == ale_pkg::REQ_INSERT) begin
					cmd.wr_sel = ale_pkg::ADDR_CUR_P1;
					if (stat.last_ins) begin
						state_d = ST_INSW;
					end else begin
						cmd.rd_en  = 1'b1;
						cmd.rd_sel = ale_pkg::ADDR_CUR_M1;
					end
				end else begin
					cmd.wr_sel = ale_pkg::ADDR_CUR_M1;
					if (stat.last_del) begin
						cmd.len_op = ale_pkg::LEN_DEC;
						state_d    = ST_RESP;
					end else begin
						cmd.rd_en  = 1'b1;
						cmd.rd_sel = ale_pkg::ADDR_CUR_P1;
					end
				end
			end
			ST_INSW: begin
				// drop the new word into the opened slot
				cmd.wr_en  = 1'b1;
				cmd.wr_sel = ale_pkg::ADDR_POS_M1;
				cmd.len_op = ale_pkg::LEN_INC;
				state_d    = ST_RESP;
			end
			ST_RESP: begin
				if (stat.out_free) begin
					cmd.out_load = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

FILE: src/ale_dp.sv
// Datapath for the array list engine: request word, length, element memory and reply.
// Executes commands from ale_ctrl and reports range checks back to it.
// Depends on ale_pkg.
module ale_dp #(
	parameter int CAPACITY   = 64,
	parameter int ELEM_WIDTH = 32
) (
	input  logic               clk,
	input  logic               arst_n,
	input  ale_pkg::ale_cmd_t  cmd,
	output ale_pkg::ale_stat_t stat,
	input  logic [2:0]         req_type,
	input  logic [6:0]         position,
	input  logic [31:0]        elem_value,
	output logic               out_valid,
	input  logic               out_stall,
	output logic               ok,
	output logic [31:0]        read_value,
	output logic [6:0]         list_length
);

	localparam int SW = (ELEM_WIDTH < 32) ? ELEM_WIDTH : 32;  // stored word width
	localparam int AW = $clog2(CAPACITY);                     // entry index width
	localparam int LW = $clog2(CAPACITY + 1);                 // length width
	localparam int CW = ((LW > 7) ? LW : 7) + 1;              // compare width

	logic [2:0]    kind_q;
	logic [6:0]    pos_q;
	logic [SW-1:0] val_q;
	logic [LW-1:0] len_q;
	logic [AW-1:0] cur_q;
	logic [SW-1:0] rdata_q;
	logic          res_ok_q;
	logic          out_valid_q;
	logic          ok_q;
	logic [31:0]   read_value_q;
	logic [6:0]    list_length_q;

	logic [SW-1:0] mem [CAPACITY];

	logic [CW-1:0] pos_w;
	logic [CW-1:0] len_w;
	logic [CW-1:0] cur_w;
	logic          pos_in;
	logic          full;
	logic          req_ok;
	logic [AW-1:0] rd_addr;
	logic [AW-1:0] wr_addr;
	logic [SW-1:0] wdata;

	assign pos_w = CW'(pos_q);
	assign len_w = CW'(len_q);
	assign cur_w = CW'(cur_q);

	// range checks against the current length
	assign pos_in = (pos_w != '0) && (pos_w <= len_w);
	assign full   = (len_w == CW'(CAPACITY));

	always_comb begin
		case (kind_q)
			ale_pkg::REQ_CLEAR:  req_ok = 1'b1;
			ale_pkg::REQ_GET:    req_ok = pos_in;
			ale_pkg::REQ_UPDATE: req_ok = pos_in;
			ale_pkg::REQ_DELETE: req_ok = pos_in;
			ale_pkg::REQ_INSERT: req_ok = (pos_w != '0) && (pos_w <= len_w + CW'(1)) && !full;
			ale_pkg::REQ_APPEND: req_ok = !full;
			default:             req_ok = 1'b0;
		endcase
	end

	assign stat.kind     = kind_q;
	assign stat.req_ok   = req_ok;
	assign stat.move     = (kind_q == ale_pkg::REQ_INSERT) ? (pos_w <= len_w) : (pos_w < len_w);
	assign stat.last_ins = (cur_w == pos_w - CW'(1));
	assign stat.last_del = (cur_w == len_w - CW'(1));
	assign stat.out_free = !out_valid_q || !out_stall;

	// read address select
	always_comb begin
		case (cmd.rd_sel)
			ale_pkg::ADDR_POS_M1: rd_addr = AW'(pos_w - CW'(1));
			ale_pkg::ADDR_POS:    rd_addr = AW'(pos_w);
			ale_pkg::ADDR_LEN:    rd_addr = AW'(len_w);
			ale_pkg::ADDR_LEN_M1: rd_addr = AW'(len_w - CW'(1));
			ale_pkg::ADDR_CUR_P1: rd_addr = AW'(cur_w + CW'(1));
			ale_pkg::ADDR_CUR_M1: rd_addr = AW'(cur_w - CW'(1));
			default:              rd_addr = '0;
		endcase
	end

	// write address select
	always_comb begin
		case (cmd.wr_sel)
			ale_pkg::ADDR_POS_M1: wr_addr = AW'(pos_w - CW'(1));
			ale_pkg::ADDR_POS:    wr_addr = AW'(pos_w);
			ale_pkg::ADDR_LEN:    wr_addr = AW'(len_w);
			ale_pkg::ADDR_LEN_M1: wr_addr = AW'(len_w - CW'(1));
			ale_pkg::ADDR_CUR_P1: wr_addr = AW'(cur_w + CW'(1));
			ale_pkg::ADDR_CUR_M1: wr_addr = AW'(cur_w - CW'(1));
			default:              wr_addr = '0;
		endcase
	end

	assign wdata = cmd.wr_from_rd ? rdata_q : val_q;

	// element memory, one write and one registered read per cycle
	always_ff @(posedge clk) begin
		if (cmd.wr_en) begin
			mem[wr_addr] <= wdata;
		end
		if (cmd.rd_en) begin
			rdata_q <= mem[rd_addr];
			cur_q   <= rd_addr;
		end
	end

	// request word and result flag
	always_ff @(posedge clk) begin
		if (cmd.load_req) begin
			kind_q <= req_type;
			pos_q  <= position;
			val_q  <= SW'(elem_value);
		end
		if (cmd.res_latch) begin
			res_ok_q <= req_ok;
		end
	end

	// list length
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q <= '0;
		end else begin
			case (cmd.len_op)
				ale_pkg::LEN_CLEAR: len_q <= '0;
				ale_pkg::LEN_INC:   len_q <= len_q + LW'(1);
				ale_pkg::LEN_DEC:   len_q <= len_q - LW'(1);
				default:            len_q <= len_q;
			endcase
		end
	end

	// output register: valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	// output register: word
	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			ok_q          <= res_ok_q;
			read_value_q  <= (res_ok_q && kind_q == ale_pkg::REQ_GET) ? 32'(rdata_q) : '0;
			list_length_q <= 7'(len_q);
		end
	end

	assign out_valid   = out_valid_q;
	assign ok          = ok_q;
	assign read_value  = read_value_q;
	assign list_length = list_length_q;

endmodule

FILE: src/array_list_engine.sv
// Array list engine: fixed-capacity ordered list with clear, get, update, insert, delete, append.
// Every request passes through the check and reply states; an insert or delete that must move entries
// also passes through the shift state (and an insert then through the slot write state), and shifts move
// one entry per cycle through the element memory.
// One request at a time: the next word is taken the cycle after its result is registered.
// Reset clears the length and the control state; element memory is not cleared.
module array_list_engine #(
	parameter int CAPACITY   = 64,
	parameter int ELEM_WIDTH = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [2:0]  req_type,
	input  logic [6:0]  position,
	input  logic [31:0] elem_value,
	output logic        out_valid,
	input  logic        out_stall,
	output logic        ok,
	output logic [31:0] read_value,
	output logic [6:0]  list_length
);

	ale_pkg::ale_cmd_t  cmd;
	ale_pkg::ale_stat_t stat;

	// sequencer
	ale_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.stat     (stat),
		.cmd      (cmd)
	);

	// storage and arithmetic
	ale_dp #(
		.CAPACITY   (CAPACITY),
		.ELEM_WIDTH (ELEM_WIDTH)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.stat        (stat),
		.req_type    (req_type),
		.position    (position),
		.elem_value  (elem_value),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.ok          (ok),
		.read_value  (read_value),
		.list_length (list_length)
	);

endmodule

FILE: src/ale_checker.sv
// Port-level checks for the array list engine, attached by bind.
// Watches only the top level's ports. Depends on array_list_engine.
module ale_checker #(
	parameter int CAPACITY = 64
) (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_stall,
	input logic        out_valid,
	input logic        out_stall,
	input logic        ok,
	input logic [31:0] read_value,
	input logic [6:0]  list_length
);

	// a waiting result word holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(ok) && $stable(read_value)
			&& $stable(list_length))
		else $error("result word changed while stalled");

	// one request at a time: an accepted word closes the input
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("second word accepted while busy");

	// a refused request reads nothing
	a_refused_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !ok |-> read_value == 32'd0)
		else $error("refused request returned data");

	// length never beyond capacity
	a_len_bound: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (CAPACITY > 127) || (32'(list_length) <= CAPACITY))
		else $error("length beyond capacity");

endmodule

bind array_list_engine ale_checker #(
	.CAPACITY (CAPACITY)
) u_ale_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_valid    (in_valid),
	.in_stall    (in_stall),
	.out_valid   (out_valid),
	.out_stall   (out_stall),
	.ok          (ok),
	.read_value  (read_value),
	.list_length (list_length)
);

FILE: bench/tb_array_list_engine.sv
// Testbench for array_list_engine: a directed table of requests, then random request streams.
// Typed table rows are checked against their expected reply, all others against an in-bench list model.
// Depends on ale_pkg (request codes) and the array_list_engine RTL.
module tb_array_list_engine;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int LIST_CAP = 64;
	localparam int DIR_ROWS = 25;

	// request codes the block does not know; both must be refused
	localparam logic [2:0] REQ_UNUSED_A = 3'd6;
	localparam logic [2:0] REQ_UNUSED_B = 3'd7;

	typedef struct packed {
		logic        ok;
		logic [31:0] rd;
		logic [6:0]  len;
	} reply_t;

	// one row of the directed table; want is used only when typed is set
	typedef struct packed {
		logic [2:0]  kind;
		logic [6:0]  pos;
		logic [31:0] val;
		logic        typed;
		reply_t      want;
	} step_row_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [2:0]  req_type = ale_pkg::REQ_CLEAR;
	logic [6:0]  position = 7'd0;
	logic [31:0] elem_value = 32'd0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic        ok;
	logic [31:0] read_value;
	logic [6:0]  list_length;

	// model of the list contents
	bit [31:0] list_words [LIST_CAP];
	int        list_fill = 0;
	bit        growing = 1'b1;

	reply_t stored_replies [$];
	int     reply_errors = 0;
	int     send_idle_pct = 0;
	int     stall_pct = 0;

	step_row_t directed_rows [DIR_ROWS] = '{
		// empty list after reset: every position refused
		'{ale_pkg::REQ_GET,    7'd1,   32'h0000_0000, 1'b1, '{1'b0, 32'h0000_0000, 7'd0}},
		'{ale_pkg::REQ_DELETE, 7'd1,   32'h0000_0000, 1'b1, '{1'b0, 32'h0000_0000, 7'd0}},
		'{ale_pkg::REQ_UPDATE, 7'd1,   32'hFFFF_FFFF, 1'b1, '{1'b0, 32'h0000_0000, 7'd0}},
		'{ale_pkg::REQ_INSERT, 7'd0,   32'h0000_0000, 1'b1, '{1'b0, 32'h0000_0000, 7'd0}},
		'{ale_pkg::REQ_INSERT, 7'd2,   32'h0000_0000, 1'b1, '{1'b0, 32'h0000_0000, 7'd0}},
		// first entries, extreme words
		'{ale_pkg::REQ_INSERT, 7'd1,   32'hFFFF_FFFF, 1'b1, '{1'b1, 32'h0000_0000, 7'd1}},
		'{ale_pkg::REQ_APPEND, 7'd127, 32'h0000_0000, 1'b1, '{1'b1, 32'h0000_0000, 7'd2}},
		'{ale_pkg::REQ_GET,    7'd1,   32'h0000_0000, 1'b1, '{1'b1, 32'hFFFF_FFFF, 7'd2}},
		'{ale_pkg::REQ_GET,    7'd2,   32'hFFFF_FFFF, 1'b1, '{1'b1, 32'h0000_0000, 7'd2}},
		'{ale_pkg::REQ_GET,    7'd0,   32'h0000_0000, 1'b1, '{1'b0, 32'h0000_0000, 7'd2}},
		'{ale_pkg::REQ_GET,    7'd127, 32'h0000_0000, 1'b1, '{1'b0, 32'h0000_0000, 7'd2}},
		'{ale_pkg::REQ_UPDATE, 7'd2,   32'hA5A5_A5A5, 1'b1, '{1'b1, 32'h0000_0000, 7'd2}},
		// unknown codes leave the list alone
		'{REQ_UNUSED_A,        7'd1,   32'h0000_0000, 1'b1, '{1'b0, 32'h0000_0000, 7'd2}},
		'{REQ_UNUSED_B,        7'd127, 32'hFFFF_FFFF, 1'b1, '{1'b0, 32'h0000_0000, 7'd2}},
		// insert just past the end, then with shifting
		'{ale_pkg::REQ_INSERT, 7'd3,   32'h5A5A_5A5A, 1'b1, '{1'b1, 32'h0000_0000, 7'd3}},
		'{ale_pkg::REQ_INSERT, 7'd1,   32'h1234_5678, 1'b0, '0},
		'{ale_pkg::REQ_INSERT, 7'd2,   32'h0F0F_0F0F, 1'b0, '0},
		'{ale_pkg::REQ_DELETE, 7'd1,   32'h0000_0000, 1'b0, '0},
		'{ale_pkg::REQ_DELETE, 7'd4,   32'h0000_0000, 1'b0, '0},
		'{ale_pkg::REQ_DELETE, 7'd4,   32'h0000_0000, 1'b1, '{1'b0, 32'h0000_0000, 7'd3}},
		'{ale_pkg::REQ_GET,    7'd2,   32'h0000_0000, 1'b0, '0},
		'{ale_pkg::REQ_GET,    7'd3,   32'h0000_0000, 1'b0, '0},
		// clear keeps the words but empties the list
		'{ale_pkg::REQ_CLEAR,  7'd55,  32'hFFFF_FFFF, 1'b1, '{1'b1, 32'h0000_0000, 7'd0}},
		'{ale_pkg::REQ_GET,    7'd1,   32'h0000_0000, 1'b1, '{1'b0, 32'h0000_0000, 7'd0}},
		'{ale_pkg::REQ_APPEND, 7'd0,   32'hDEAD_BEEF, 1'b1, '{1'b1, 32'h0000_0000, 7'd1}}
	};

	array_list_engine u_top (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.req_type    (req_type),
		.position    (position),
		.elem_value  (elem_value),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.ok          (ok),
		.read_value  (read_value),
		.list_length (list_length)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// apply one request to the list model and return its reply
	function automatic reply_t list_apply(logic [2:0] kind, logic [6:0] pos, logic [31:0] val);
		reply_t r;
		int     p;
		int     j;
		r = '0;
		p = int'(pos);
		case (kind)
			ale_pkg::REQ_CLEAR: begin
				list_fill = 0;
				r.ok = 1'b1;
			end
			ale_pkg::REQ_GET: begin
				if (p >= 1 && p <= list_fill) begin
					r.rd = list_words[p - 1];
					r.ok = 1'b1;
				end
			end
			ale_pkg::REQ_UPDATE: begin
				if (p >= 1 && p <= list_fill) begin
					list_words[p - 1] = val;
					r.ok = 1'b1;
				end
			end
			ale_pkg::REQ_INSERT: begin
				if (p >= 1 && p <= list_fill + 1 && list_fill < LIST_CAP) begin
					for (j = list_fill; j >= p; j--)
						list_words[j] = list_words[j - 1];
					list_words[p - 1] = val;
					list_fill++;
					r.ok = 1'b1;
				end
			end
			ale_pkg::REQ_DELETE: begin
				if (p >= 1 && p <= list_fill) begin
					for (j = p; j < list_fill; j++)
						list_words[j - 1] = list_words[j];
					list_fill--;
					r.ok = 1'b1;
				end
			end
			ale_pkg::REQ_APPEND: begin
				if (list_fill < LIST_CAP) begin
					list_words[list_fill] = val;
					list_fill++;
					r.ok = 1'b1;
				end
			end
			default: ;
		endcase
		r.len = 7'(list_fill);
		return r;
	endfunction

	// random request: mostly legal positions, the list swinging between empty and full
	task automatic pick_request(output logic [2:0] kind, output logic [6:0] pos,
			output logic [31:0] val);
		int roll;
		int pr;
		int lim;
		if (list_fill == 0)
			growing = 1'b1;
		else if (list_fill == LIST_CAP && $urandom_range(3) == 0)
			growing = 1'b0;
		roll = $urandom_range(99);
		val = $urandom;
		if (roll < 3)
			kind = roll[0] ? REQ_UNUSED_A : REQ_UNUSED_B;
		else if (growing) begin
			if (roll < 40)      kind = ale_pkg::REQ_APPEND;
			else if (roll < 65) kind = ale_pkg::REQ_INSERT;
			else if (roll < 78) kind = ale_pkg::REQ_GET;
			else if (roll < 90) kind = ale_pkg::REQ_UPDATE;
			else                kind = ale_pkg::REQ_DELETE;
		end else begin
			if (roll < 5)       kind = ale_pkg::REQ_CLEAR;
			else if (roll < 55) kind = ale_pkg::REQ_DELETE;
			else if (roll < 67) kind = ale_pkg::REQ_GET;
			else if (roll < 79) kind = ale_pkg::REQ_UPDATE;
			else if (roll < 89) kind = ale_pkg::REQ_INSERT;
			else                kind = ale_pkg::REQ_APPEND;
		end
		lim = (kind == ale_pkg::REQ_INSERT) ? list_fill + 1 : list_fill;
		pr = $urandom_range(9);
		if (pr == 0 || lim == 0)
			pos = 7'($urandom_range(127));
		else if (pr == 1)
			pos = $urandom_range(1) ? 7'd0 : 7'(lim + 1 + $urandom_range(1));
		else
			pos = 7'($urandom_range(lim, 1));
	endtask

	// offer one request word; on acceptance record the reply it must give
	task automatic send_word(logic [2:0] kind, logic [6:0] pos, logic [31:0] val,
			logic typed, reply_t want);
		reply_t got;
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid   <= 1'b1;
		req_type   <= kind;
		position   <= pos;
		elem_value <= val;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		got = list_apply(kind, pos, val);
		stored_replies.push_back(typed ? want : got);
	endtask

	// hold off the sender until every outstanding reply is back
	task automatic drain_replies();
		in_valid <= 1'b0;
		while (stored_replies.size() != 0)
			@(posedge clk);
	endtask

	// receiver back-pressure
	always @(posedge clk)
		out_stall <= ($urandom_range(99) < stall_pct);

	// reply checker
	always @(posedge clk) begin : check_replies
		reply_t want;
		reply_t seen;
		if (arst_n && out_valid && !out_stall) begin
			seen = '{ok, read_value, list_length};
			if (stored_replies.size() == 0) begin
				if (reply_errors < 10)
					$display("%0t: reply word with none pending: ok=%0b rd=%h len=%0d",
						$realtime, seen.ok, seen.rd, seen.len);
				reply_errors++;
			end else begin
				want = stored_replies.pop_front();
				if (seen.ok !== want.ok || seen.rd !== want.rd || seen.len !== want.len) begin
					if (reply_errors < 10)
						$display("%0t: reply mismatch: exp ok=%0b rd=%h len=%0d, got ok=%0b rd=%h len=%0d",
							$realtime, want.ok, want.rd, want.len, seen.ok, seen.rd, seen.len);
					reply_errors++;
				end
			end
		end
	end

	initial begin : stimulus
		int          i;
		int          phase;
		logic [2:0]  k;
		logic [6:0]  p;
		logic [31:0] v;
		send_idle_pct = 25;
		stall_pct = 83;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed table
		for (i = 0; i < DIR_ROWS; i++)
			send_word(directed_rows[i].kind, directed_rows[i].pos, directed_rows[i].val,
				directed_rows[i].typed, directed_rows[i].want);
		drain_replies();

		// random streams under three idling patterns
		for (phase = 0; phase < 3; phase++) begin
			case (phase)
				0: begin send_idle_pct = 25; stall_pct = 83; end
				1: begin send_idle_pct = 83; stall_pct = 25; end
				default: begin send_idle_pct = 0; stall_pct = 0; end
			endcase
			repeat (417) begin
				pick_request(k, p, v);
				send_word(k, p, v, 1'b0, '0);
			end
			drain_replies();
		end

		// let a stray late reply word show up before the verdict
		repeat (80) @(posedge clk);
		if (reply_errors == 0 && stored_replies.size() == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

	// watchdog
	initial begin
		#18_000_000;
		$display("TEST FAILED");
		$finish;
	end

endmodule
